[rtl/phsr_pkg.sv]
// ----------------------------------------------------------------------------
// phsr_pkg
// Types and constants shared by the pulse height spectrum and rate block.
// ----------------------------------------------------------------------------
package phsr_pkg;

    localparam int CMD_W      = 2;
    localparam int AMP_W      = 12;
    localparam int BIN_IDX_W  = 11;
    localparam int START_W    = 11;
    localparam int DIV_W      = 16;
    localparam int SLOT_W     = 16;
    localparam int BIN_W      = 32;
    localparam int ACC_W      = 32;
    localparam int RATE_W     = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // power of two, pointers wrap naturally
    localparam int Q_DEPTH    = 2;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);

    localparam logic [SLOT_W-1:0] SLOT_MAX = '1;
    localparam logic [BIN_W-1:0]  BIN_MAX  = '1;
    localparam logic [RATE_W-1:0] RATE_MAX = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_PULSE = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_READ  = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_CHANNEL = 2'd0,
        CFG_SPECTRUM_MODE = 2'd1,
        CFG_SOUND_ON      = 2'd2,
        CFG_CLICK_DIVIDER = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        OP_DROP,
        OP_PULSE_RATE,
        OP_PULSE_BIN,
        OP_PULSE_CLICK,
        OP_TICK,
        OP_TICK_ACC,
        OP_CLEAR,
        OP_READ,
        OP_READ_ZERO
    } t_op_kind;

    typedef struct packed {
        t_op_kind               kind;
        logic [BIN_IDX_W-1:0]   bin;
    } t_op;

    typedef struct packed {
        logic               sound_on;
        logic [DIV_W-1:0]   divider;
    } t_click_cfg;

    typedef struct packed {
        logic               click;
        logic [RATE_W-1:0]  rate_count;
        logic [ACC_W-1:0]   accum_time;
        logic [BIN_W-1:0]   bin_value;
    } t_result;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_RMW,
        ST_READ,
        ST_CLEAR
    } t_state;

endpackage

[rtl/phsr_ifs.sv]
// ----------------------------------------------------------------------------
// phsr interfaces
// Valid/ready channels: command input, result output, register writes.
// ----------------------------------------------------------------------------
interface phsr_in_if import phsr_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CMD_W-1:0]       command;
    logic [AMP_W-1:0]       amplitude;
    logic                   pump_busy;
    logic [BIN_IDX_W-1:0]   bin_index;

    modport source (output valid, command, amplitude, pump_busy, bin_index, input ready);
    modport sink   (input valid, command, amplitude, pump_busy, bin_index, output ready);
endinterface

interface phsr_out_if import phsr_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   click;
    logic [RATE_W-1:0]      rate_count;
    logic [ACC_W-1:0]       accum_time;
    logic [BIN_W-1:0]       bin_value;

    modport source (output valid, click, rate_count, accum_time, bin_value, input ready);
    modport sink   (input valid, click, rate_count, accum_time, bin_value, output ready);
endinterface

interface phsr_cfg_if import phsr_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/phsr_ram.sv]
// ----------------------------------------------------------------------------
// phsr_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module phsr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/phsr_front.sv]
// ----------------------------------------------------------------------------
// phsr_front
// Holds the configuration registers, accepts commands and classifies them
// into operations for the back end.
// ----------------------------------------------------------------------------
module phsr_front import phsr_pkg::*; #(
    parameter int NUM_BINS = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    phsr_cfg_if.sink    i_cfg,
    phsr_in_if.sink     i_in,
    input  logic        i_full,
    input  logic        i_sweeping,
    output logic        o_push,
    output t_op         o_op,
    output t_click_cfg  o_click_cfg
);

    localparam logic [BIN_IDX_W+1:0] NB = (BIN_IDX_W+2)'(NUM_BINS);

    logic [START_W-1:0] r_start_channel;
    logic               r_spectrum_mode;
    logic               r_sound_on;
    logic [DIV_W-1:0]   r_click_divider;

    logic [BIN_IDX_W-1:0] amp_bin;
    logic                 drop;
    logic                 amp_in_range;
    logic                 idx_in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_channel <= '0;
            r_spectrum_mode <= 1'b0;
            r_sound_on      <= 1'b1;
            r_click_divider <= '0;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_START_CHANNEL: r_start_channel <= i_cfg.data[START_W-1:0];
                CFG_SPECTRUM_MODE: r_spectrum_mode <= i_cfg.data[0];
                CFG_SOUND_ON:      r_sound_on      <= i_cfg.data[0];
                CFG_CLICK_DIVIDER: r_click_divider <= i_cfg.data[DIV_W-1:0];
                default: ;
            endcase
        end
    end

    assign i_cfg.ready = 1'b1;

    assign amp_bin      = i_in.amplitude[AMP_W-1:1];
    assign drop         = i_in.pump_busy || (i_in.amplitude < {r_start_channel, 1'b0});
    assign amp_in_range = ((BIN_IDX_W+2)'(amp_bin) < NB);
    assign idx_in_range = ((BIN_IDX_W+2)'(i_in.bin_index) < NB);

    always_comb begin
        o_op.bin  = amp_bin;
        o_op.kind = OP_DROP;
        case (t_cmd'(i_in.command))
            CMD_PULSE: begin
                if (drop) begin
                    o_op.kind = OP_DROP;
                end else if (r_spectrum_mode) begin
                    o_op.kind = amp_in_range ? OP_PULSE_BIN : OP_PULSE_RATE;
                end else begin
                    o_op.kind = OP_PULSE_CLICK;
                end
            end
            CMD_TICK:  o_op.kind = r_spectrum_mode ? OP_TICK_ACC : OP_TICK;
            CMD_CLEAR: o_op.kind = OP_CLEAR;
            CMD_READ: begin
                o_op.bin  = i_in.bin_index;
                o_op.kind = idx_in_range ? OP_READ : OP_READ_ZERO;
            end
            default: o_op.kind = OP_DROP;
        endcase
    end

    assign i_in.ready           = !i_full && !i_sweeping;
    assign o_push               = i_in.valid && i_in.ready;
    assign o_click_cfg.sound_on = r_sound_on;
    assign o_click_cfg.divider  = r_click_divider;

endmodule

[rtl/phsr_queue.sv]
// ----------------------------------------------------------------------------
// phsr_queue
// Short operation queue between front and back end.
// ----------------------------------------------------------------------------
module phsr_queue import phsr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_op     i_data,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_valid,
    output t_op     o_data
);

    t_op                r_entries [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_PTR_W:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entries[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_full  = (r_count == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_entries[r_rd_ptr];

endmodule

[rtl/phsr_back.sv]
// ----------------------------------------------------------------------------
// phsr_back
// Executes operations: histogram read-modify-write and clear sweep, rate
// window with running sum, click divider, accumulation time, result register.
// ----------------------------------------------------------------------------
module phsr_back import phsr_pkg::*; #(
    parameter int NUM_BINS     = 2048,
    parameter int WINDOW_SLOTS = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_op_valid,
    input  t_op         i_op,
    output logic        o_op_pop,
    input  t_click_cfg  i_click_cfg,
    output logic        o_sweeping,
    phsr_out_if.source  o_out
);

    localparam int AW    = $clog2(NUM_BINS);
    localparam int SUM_W = $clog2(WINDOW_SLOTS * SLOT_MAX + 1);
    localparam logic [AW-1:0] LAST_BIN = AW'(NUM_BINS - 1);

    t_state              r_state, n_state;
    logic [AW-1:0]       r_sweep, n_sweep;
    logic [AW-1:0]       r_addr,  n_addr;
    logic [SLOT_W-1:0]   r_slots [WINDOW_SLOTS];
    logic [SLOT_W-1:0]   n_slots [WINDOW_SLOTS];
    logic [SUM_W-1:0]    r_wsum,  n_wsum;
    logic [DIV_W-1:0]    r_click_cnt, n_click_cnt;
    logic [ACC_W-1:0]    r_accum, n_accum;
    logic                r_out_valid, n_out_valid;
    t_result             r_out,   n_out;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [BIN_W-1:0]    ram_wdata;
    logic                ram_re;
    logic [BIN_W-1:0]    ram_rdata;

    logic [AW+BIN_IDX_W-1:0] op_wide;
    logic [AW-1:0]           op_addr;
    logic [SUM_W+RATE_W-1:0] half_sum;
    logic [RATE_W-1:0]       rate_sat;
    logic                    out_free;
    logic                    click_hit;

    phsr_ram #(
        .WIDTH (BIN_W),
        .DEPTH (NUM_BINS)
    ) u_bins (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (op_addr),
        .o_rdata (ram_rdata)
    );

    assign op_wide   = {{AW{1'b0}}, i_op.bin};
    assign op_addr   = op_wide[AW-1:0];
    assign half_sum  = (SUM_W+RATE_W)'(r_wsum >> 1);
    assign rate_sat  = (half_sum > (SUM_W+RATE_W)'(RATE_MAX)) ? RATE_MAX
                                                             : half_sum[RATE_W-1:0];
    assign out_free  = !r_out_valid || o_out.ready;
    assign click_hit = (r_click_cnt > i_click_cfg.divider) && (i_click_cfg.divider != '0)
                       && i_click_cfg.sound_on;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_sweep     <= '0;
            r_wsum      <= '0;
            r_click_cnt <= '0;
            r_accum     <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < WINDOW_SLOTS; i++) begin
                r_slots[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_wsum      <= n_wsum;
            r_click_cnt <= n_click_cnt;
            r_accum     <= n_accum;
            r_out_valid <= n_out_valid;
            r_slots     <= n_slots;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_out  <= n_out;
    end

    always_comb begin
        logic bump;
        bump        = 1'b0;
        n_state     = r_state;
        n_sweep     = r_sweep;
        n_addr      = r_addr;
        n_slots     = r_slots;
        n_wsum      = r_wsum;
        n_click_cnt = r_click_cnt;
        n_accum     = r_accum;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out       = r_out;
        ram_we      = 1'b0;
        ram_waddr   = r_sweep;
        ram_wdata   = '0;
        ram_re      = 1'b0;
        o_op_pop    = 1'b0;

        case (r_state)
            ST_INIT, ST_CLEAR: begin
                ram_we = 1'b1;
                if (r_sweep == LAST_BIN) begin
                    n_sweep = '0;
                    n_state = ST_IDLE;
                    if (r_state == ST_CLEAR) begin
                        n_out_valid = 1'b1;
                        n_out       = '{click: 1'b0, rate_count: '0,
                                        accum_time: r_accum, bin_value: '0};
                    end
                end else begin
                    n_sweep = r_sweep + 1'b1;
                end
            end
            ST_RMW: begin
                ram_we      = 1'b1;
                ram_waddr   = r_addr;
                ram_wdata   = (ram_rdata == BIN_MAX) ? ram_rdata : ram_rdata + 1'b1;
                n_out_valid = 1'b1;
                n_out       = '{click: 1'b0, rate_count: '0,
                                accum_time: r_accum, bin_value: '0};
                n_state     = ST_IDLE;
            end
            ST_READ: begin
                n_out_valid = 1'b1;
                n_out       = '{click: 1'b0, rate_count: '0,
                                accum_time: r_accum, bin_value: ram_rdata};
                n_state     = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_op_valid && out_free) begin
                    o_op_pop    = 1'b1;
                    n_out_valid = 1'b1;
                    n_out       = '{click: 1'b0, rate_count: '0,
                                    accum_time: r_accum, bin_value: '0};
                    case (i_op.kind)
                        OP_DROP, OP_READ_ZERO: ;
                        OP_PULSE_RATE: bump = 1'b1;
                        OP_PULSE_BIN: begin
                            bump        = 1'b1;
                            ram_re      = 1'b1;
                            n_addr      = op_addr;
                            n_out_valid = 1'b0;
                            n_state     = ST_RMW;
                        end
                        OP_PULSE_CLICK: begin
                            bump = 1'b1;
                            if (click_hit) begin
                                n_click_cnt = '0;
                                n_out.click = 1'b1;
                            end else begin
                                n_click_cnt = r_click_cnt + 1'b1;
                            end
                        end
                        OP_TICK, OP_TICK_ACC: begin
                            if (i_op.kind == OP_TICK_ACC) begin
                                n_accum = r_accum + 1'b1;
                            end
                            n_out.rate_count = rate_sat;
                            n_out.accum_time = n_accum;
                            n_wsum = r_wsum - SUM_W'(r_slots[WINDOW_SLOTS-1]);
                            for (int i = WINDOW_SLOTS - 1; i > 0; i--) begin
                                n_slots[i] = r_slots[i-1];
                            end
                            n_slots[0] = '0;
                        end
                        OP_CLEAR: begin
                            n_accum     = '0;
                            n_sweep     = '0;
                            n_out_valid = 1'b0;
                            n_state     = ST_CLEAR;
                        end
                        OP_READ: begin
                            ram_re      = 1'b1;
                            n_out_valid = 1'b0;
                            n_state     = ST_READ;
                        end
                        default: ;
                    endcase
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (bump && (r_slots[0] != SLOT_MAX)) begin
            n_slots[0] = r_slots[0] + 1'b1;
            n_wsum     = r_wsum + 1'b1;
        end
    end

    assign o_sweeping       = (r_state == ST_INIT);
    assign o_out.valid      = r_out_valid;
    assign o_out.click      = r_out.click;
    assign o_out.rate_count = r_out.rate_count;
    assign o_out.accum_time = r_out.accum_time;
    assign o_out.bin_value  = r_out.bin_value;

endmodule

[rtl/pulse_height_spectrum_and_rate.sv]
// ----------------------------------------------------------------------------
// pulse_height_spectrum_and_rate
// Pulse height histogram, sliding count rate window and search mode clicks.
//
//   channel  dir  payload                                        accepted when
//   i_in     in   command, amplitude, pump_busy, bin_index        valid & ready
//   o_out    out  click, rate_count, accum_time, bin_value        valid & ready
//   i_cfg    in   index, data                                    valid & ready
//
// Front end classifies a command in its accept cycle; a 2-entry queue feeds
// the back end. Back end: a histogram pulse or a bin read does a RAM read
// then write/return; a clear sweeps all NUM_BINS bins, one bin written per
// cycle. After reset the bin RAM is swept with i_in.ready low. The back end
// pops no operation while a pending result stalls on o_out.
// ----------------------------------------------------------------------------
module pulse_height_spectrum_and_rate import phsr_pkg::*; #(
    parameter int NUM_BINS     = 2048,
    parameter int WINDOW_SLOTS = 20
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    phsr_in_if.sink     i_in,
    phsr_cfg_if.sink    i_cfg,
    phsr_out_if.source  o_out
);

    logic       push;
    logic       pop;
    logic       full;
    logic       q_valid;
    logic       sweeping;
    t_op        front_op;
    t_op        back_op;
    t_click_cfg click_cfg;

    phsr_front #(
        .NUM_BINS (NUM_BINS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (i_cfg),
        .i_in        (i_in),
        .i_full      (full),
        .i_sweeping  (sweeping),
        .o_push      (push),
        .o_op        (front_op),
        .o_click_cfg (click_cfg)
    );

    phsr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_op),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (back_op)
    );

    phsr_back #(
        .NUM_BINS     (NUM_BINS),
        .WINDOW_SLOTS (WINDOW_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (q_valid),
        .i_op        (back_op),
        .o_op_pop    (pop),
        .i_click_cfg (click_cfg),
        .o_sweeping  (sweeping),
        .o_out       (o_out)
    );

endmodule

[rtl/phsr_checker.sv]
// ----------------------------------------------------------------------------
// phsr_checker
// Port level checks on the pulse height spectrum and rate block.
// ----------------------------------------------------------------------------
module phsr_checker import phsr_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_ready,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic                i_out_click,
    input  logic [RATE_W-1:0]   i_out_rate_count,
    input  logic [ACC_W-1:0]    i_out_accum_time,
    input  logic [BIN_W-1:0]    i_out_bin_value
);

    // result held while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_click)
            && $stable(i_out_rate_count) && $stable(i_out_accum_time)
            && $stable(i_out_bin_value))
        else $error("result changed while stalled");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // bin RAM sweep keeps the input closed right after reset
    a_rst_sweep: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready)
        else $error("input open during reset sweep");

    // a transaction reports at most one of click, rate and bin value
    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_click || (i_out_rate_count != '0))
            |-> (i_out_bin_value == '0) && !(i_out_click && (i_out_rate_count != '0)))
        else $error("mixed result fields");

endmodule

bind pulse_height_spectrum_and_rate phsr_checker u_phsr_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_click      (o_out.click),
    .i_out_rate_count (o_out.rate_count),
    .i_out_accum_time (o_out.accum_time),
    .i_out_bin_value  (o_out.bin_value)
);
